/* rtl/core/supply_and_temp_window_average_defines.svh */
// Assertion macros shared by the supply and temperature window average RTL.
`ifndef SUPPLY_AND_TEMP_WINDOW_AVERAGE_DEFINES_SVH
`define SUPPLY_AND_TEMP_WINDOW_AVERAGE_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of i_clk outside reset.
`define SAE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("window average check failed");

// Next-cycle implication, checked on the rising edge of i_clk outside reset.
`define SAE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("window average check failed");

`endif

/* rtl/core/sae_pkg.sv */
// Shared constants, types and command structs of the window average block.
`default_nettype none
package sae_pkg;

    localparam int WINDOW_SIZE = 8;
    localparam int SLOT_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int VALID_W     = $clog2(WINDOW_SIZE + 1);

    localparam int COUNT_W  = 10;
    localparam int REF_W    = 11;
    localparam int SUPPLY_W = 16;
    localparam int TEMP_W   = 8;
    localparam int POLL_W   = 8;
    localparam int PROD_W   = 16;

    localparam logic [REF_W-1:0]    REF_RESET    = 11'd1100;
    localparam logic [SUPPLY_W-1:0] SUPPLY_MAX   = 16'hFFFF;
    localparam logic [TEMP_W-1:0]   TEMP_MAX     = 8'hFF;
    localparam logic [POLL_W-1:0]   POLL_MAX     = 8'hFF;
    localparam logic [PROD_W-1:0]   TEMP_SCALE   = 16'd50;
    localparam logic [PROD_W-1:0]   TEMP_OFFSET  = 16'd16205;

    // Division by 61 is a multiply by ceil(2^22/61) and a shift, exact for any 16-bit value.
    localparam int RECIP_W    = 17;
    localparam int TEMP_SHIFT = 22;
    localparam logic [RECIP_W-1:0]  TEMP_RECIP   = 17'd68760;
    localparam int TPROD_W    = PROD_W + RECIP_W;
    localparam int TQ_W       = TPROD_W - TEMP_SHIFT;

    localparam int SCALE_W = REF_W + COUNT_W;
    localparam int SUM_S_W = SUPPLY_W + VALID_W;
    localparam int SUM_T_W = TEMP_W + VALID_W;
    localparam int DIV_W   = (SUM_S_W > SCALE_W) ? SUM_S_W : SCALE_W;
    localparam int DVSR_W  = COUNT_W;
    localparam int STEP_W  = $clog2(DIV_W + 1);

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_REFERENCE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_UPDATE,
        ST_OUTPUT
    } t_state;

    typedef enum logic [1:0] {
        OP_SUPPLY,
        OP_AVG_SUPPLY,
        OP_AVG_TEMP
    } t_div_op;

    typedef struct packed {
        logic    load_in;
        logic    div_start;
        logic    capture;
        t_div_op op;
        logic    update;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* rtl/core/supply_and_temp_window_average.sv */
// Supply and both window averages share one radix-2 divider; temperature uses a reciprocal.
// The next poll is taken once the result is registered; no poll is taken while one is in progress.
// A finished result waits in the output register while the next poll is accepted.
// Reset is synchronous and active low: poll count, sums and reference (1100 mV) are restored.
// Window entries have no reset; only entries already written are ever summed.
`default_nettype none
`include "supply_and_temp_window_average_defines.svh"
module supply_and_temp_window_average (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [sae_pkg::COUNT_W-1:0]   i_bandgap_count,
    input  wire logic [sae_pkg::COUNT_W-1:0]   i_temperature_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [sae_pkg::SUPPLY_W-1:0]       o_average_supply_mv,
    output logic [sae_pkg::TEMP_W-1:0]         o_average_temperature,
    output logic [sae_pkg::POLL_W-1:0]         o_polls_counted,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sae_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [sae_pkg::DATA_W-1:0]    pwdata,
    output logic [sae_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    logic [sae_pkg::REF_W-1:0] r_reference;
    logic                      w_reg_sel;
    sae_pkg::t_cmd             w_cmd;
    sae_pkg::t_sts             w_sts;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[sae_pkg::ADDR_W-1:2] == sae_pkg::REG_REFERENCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference <= sae_pkg::REF_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_reference <= pwdata[sae_pkg::REF_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? sae_pkg::DATA_W'(r_reference) : '0;

    sae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sae_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_sts                 (w_sts),
        .i_reference           (r_reference),
        .i_bandgap_count       (i_bandgap_count),
        .i_temperature_count   (i_temperature_count),
        .i_out_ready           (i_out_ready),
        .o_out_valid           (o_out_valid),
        .o_average_supply_mv   (o_average_supply_mv),
        .o_average_temperature (o_average_temperature),
        .o_polls_counted       (o_polls_counted)
    );

    `SAE_ASSERT_NXT(a_busy_after_transfer, i_in_valid && o_in_ready, !o_in_ready)
    `SAE_ASSERT_IMP(a_load_only_when_free, w_cmd.load_out, w_sts.out_free)
    `SAE_ASSERT_IMP(a_result_counts_poll, o_out_valid, o_polls_counted != '0)

endmodule
`default_nettype wire

/* rtl/core/sae_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module sae_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sae_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [sae_pkg::DVSR_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [sae_pkg::DIV_W-1:0]        o_quotient
);

    logic                         r_busy;
    logic                         r_done;
    logic [sae_pkg::STEP_W-1:0]   r_step;
    logic [sae_pkg::DVSR_W-1:0]   r_rem;
    logic [sae_pkg::DVSR_W-1:0]   r_dvsr;
    logic [sae_pkg::DIV_W-1:0]    r_quo;

    logic [sae_pkg::DVSR_W:0]     w_trial;
    logic [sae_pkg::DVSR_W:0]     w_diff;
    logic                         w_ge;
    logic [sae_pkg::DVSR_W-1:0]   n_rem;
    logic [sae_pkg::DIV_W-1:0]    n_quo;

    always_comb begin
        w_trial = {r_rem, r_quo[sae_pkg::DIV_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvsr});
        w_diff  = w_trial - {1'b0, r_dvsr};
        n_rem   = w_ge ? w_diff[sae_pkg::DVSR_W-1:0] : w_trial[sae_pkg::DVSR_W-1:0];
        n_quo   = {r_quo[sae_pkg::DIV_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= sae_pkg::STEP_W'(sae_pkg::DIV_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == sae_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

/* rtl/core/sae_dp.sv */
// Datapath: conversions, sliding windows, running sums and the result register.
`default_nettype none
module sae_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sae_pkg::t_cmd                 i_cmd,
    output sae_pkg::t_sts                      o_sts,
    input  wire logic [sae_pkg::REF_W-1:0]     i_reference,
    input  wire logic [sae_pkg::COUNT_W-1:0]   i_bandgap_count,
    input  wire logic [sae_pkg::COUNT_W-1:0]   i_temperature_count,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [sae_pkg::SUPPLY_W-1:0]       o_average_supply_mv,
    output logic [sae_pkg::TEMP_W-1:0]         o_average_temperature,
    output logic [sae_pkg::POLL_W-1:0]         o_polls_counted
);

    logic [sae_pkg::COUNT_W-1:0]   r_bg;
    logic [sae_pkg::COUNT_W-1:0]   r_tc;
    logic [sae_pkg::PROD_W-1:0]    r_tdiff;
    logic [sae_pkg::SUPPLY_W-1:0]  r_supply;
    logic [sae_pkg::TEMP_W-1:0]    r_temp;
    logic [sae_pkg::SUPPLY_W-1:0]  r_avg_s;
    logic [sae_pkg::TEMP_W-1:0]    r_avg_t;
    logic [sae_pkg::SUM_S_W-1:0]   r_sum_s;
    logic [sae_pkg::SUM_T_W-1:0]   r_sum_t;
    logic [sae_pkg::SLOT_W-1:0]    r_slot;
    logic [sae_pkg::POLL_W-1:0]    r_poll;
    logic [sae_pkg::SUPPLY_W-1:0]  r_win_s [sae_pkg::WINDOW_SIZE];
    logic [sae_pkg::TEMP_W-1:0]    r_win_t [sae_pkg::WINDOW_SIZE];
    logic                          r_out_valid;
    logic [sae_pkg::SUPPLY_W-1:0]  r_out_s;
    logic [sae_pkg::TEMP_W-1:0]    r_out_t;
    logic [sae_pkg::POLL_W-1:0]    r_out_poll;

    logic [sae_pkg::SCALE_W-1:0]   w_scaled;
    logic [sae_pkg::PROD_W-1:0]    w_temp_prod;
    logic [sae_pkg::PROD_W-1:0]    w_temp_diff;
    logic                          w_cold;
    logic [sae_pkg::TPROD_W-1:0]   w_temp_scaled;
    logic [sae_pkg::TQ_W-1:0]      w_temp_q;
    logic                          w_full;
    logic [sae_pkg::VALID_W-1:0]   w_valid;
    logic [sae_pkg::DIV_W-1:0]     w_dividend;
    logic [sae_pkg::DVSR_W-1:0]    w_divisor;
    logic                          w_div_done;
    logic [sae_pkg::DIV_W-1:0]     w_quotient;
    logic [sae_pkg::SUPPLY_W-1:0]  w_old_s;
    logic [sae_pkg::TEMP_W-1:0]    w_old_t;
    logic [sae_pkg::SUM_S_W-1:0]   n_sum_s;
    logic [sae_pkg::SUM_T_W-1:0]   n_sum_t;
    logic [sae_pkg::SLOT_W-1:0]    n_slot;
    logic [sae_pkg::POLL_W-1:0]    n_poll;

    // The reference times 1023 is the reference shifted up ten bits, less itself.
    always_comb begin
        w_scaled      = {i_reference, sae_pkg::COUNT_W'(0)}
                        - sae_pkg::SCALE_W'(i_reference);
        w_temp_prod   = sae_pkg::PROD_W'(r_tc) * sae_pkg::TEMP_SCALE;
        w_cold        = (w_temp_prod <= sae_pkg::TEMP_OFFSET);
        w_temp_diff   = w_temp_prod - sae_pkg::TEMP_OFFSET;
        w_temp_scaled = sae_pkg::TPROD_W'(r_tdiff) * sae_pkg::TPROD_W'(sae_pkg::TEMP_RECIP);
        w_temp_q      = w_temp_scaled[sae_pkg::TPROD_W-1:sae_pkg::TEMP_SHIFT];
        w_full        = (r_poll >= sae_pkg::POLL_W'(sae_pkg::WINDOW_SIZE));
        w_valid       = w_full ? sae_pkg::VALID_W'(sae_pkg::WINDOW_SIZE)
                               : r_poll[sae_pkg::VALID_W-1:0];
    end

    always_comb begin
        case (i_cmd.op)
            sae_pkg::OP_SUPPLY: begin
                w_dividend = sae_pkg::DIV_W'(w_scaled);
                w_divisor  = r_bg;
            end
            sae_pkg::OP_AVG_SUPPLY: begin
                w_dividend = sae_pkg::DIV_W'(r_sum_s);
                w_divisor  = sae_pkg::DVSR_W'(w_valid);
            end
            sae_pkg::OP_AVG_TEMP: begin
                w_dividend = sae_pkg::DIV_W'(r_sum_t);
                w_divisor  = sae_pkg::DVSR_W'(w_valid);
            end
            default: begin
                w_dividend = '0;
                w_divisor  = '0;
            end
        endcase
    end

    sae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Until the window has wrapped, the slot being written holds nothing to remove.
    always_comb begin
        w_old_s = w_full ? r_win_s[r_slot] : '0;
        w_old_t = w_full ? r_win_t[r_slot] : '0;
        n_sum_s = r_sum_s - sae_pkg::SUM_S_W'(w_old_s) + sae_pkg::SUM_S_W'(r_supply);
        n_sum_t = r_sum_t - sae_pkg::SUM_T_W'(w_old_t) + sae_pkg::SUM_T_W'(r_temp);
        n_slot  = (r_slot == sae_pkg::SLOT_W'(sae_pkg::WINDOW_SIZE - 1))
                  ? '0 : r_slot + 1'b1;
        n_poll  = (r_poll != sae_pkg::POLL_MAX) ? r_poll + 1'b1 : r_poll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_s     <= '0;
            r_sum_t     <= '0;
            r_slot      <= '0;
            r_poll      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_sum_s <= n_sum_s;
                r_sum_t <= n_sum_t;
                r_slot  <= n_slot;
                r_poll  <= n_poll;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_bg <= i_bandgap_count;
            r_tc <= i_temperature_count;
        end
        r_tdiff <= w_cold ? '0 : w_temp_diff;
        if (i_cmd.capture) begin
            case (i_cmd.op)
                sae_pkg::OP_SUPPLY: begin
                    r_supply <= (|w_quotient[sae_pkg::DIV_W-1:sae_pkg::SUPPLY_W])
                                ? sae_pkg::SUPPLY_MAX : w_quotient[sae_pkg::SUPPLY_W-1:0];
                    r_temp   <= (|w_temp_q[sae_pkg::TQ_W-1:sae_pkg::TEMP_W])
                                ? sae_pkg::TEMP_MAX : w_temp_q[sae_pkg::TEMP_W-1:0];
                end
                sae_pkg::OP_AVG_SUPPLY: begin
                    r_avg_s <= w_quotient[sae_pkg::SUPPLY_W-1:0];
                end
                default: begin
                    r_avg_t <= w_quotient[sae_pkg::TEMP_W-1:0];
                end
            endcase
        end
        if (i_cmd.update) begin
            r_win_s[r_slot] <= r_supply;
            r_win_t[r_slot] <= r_temp;
        end
        if (i_cmd.load_out) begin
            r_out_s    <= r_avg_s;
            r_out_t    <= r_avg_t;
            r_out_poll <= r_poll;
        end
    end

    assign o_sts.div_done        = w_div_done;
    assign o_sts.out_free        = !r_out_valid || i_out_ready;
    assign o_out_valid           = r_out_valid;
    assign o_average_supply_mv   = r_out_s;
    assign o_average_temperature = r_out_t;
    assign o_polls_counted       = r_out_poll;

endmodule
`default_nettype wire

/* rtl/core/sae_ctrl.sv */
// Controller state machine that sequences the three divisions of each poll.
`default_nettype none
module sae_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire sae_pkg::t_sts  i_sts,
    output sae_pkg::t_cmd       o_cmd
);

    sae_pkg::t_state  r_state;
    sae_pkg::t_state  n_state;
    sae_pkg::t_div_op r_op;
    sae_pkg::t_div_op n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sae_pkg::ST_IDLE;
            r_op    <= sae_pkg::OP_SUPPLY;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            sae_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sae_pkg::ST_DIV_START;
                    n_op    = sae_pkg::OP_SUPPLY;
                end
            end
            sae_pkg::ST_DIV_START: begin
                n_state = sae_pkg::ST_DIV_WAIT;
            end
            sae_pkg::ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    case (r_op)
                        sae_pkg::OP_SUPPLY: begin
                            n_state = sae_pkg::ST_UPDATE;
                        end
                        sae_pkg::OP_AVG_SUPPLY: begin
                            n_state = sae_pkg::ST_DIV_START;
                            n_op    = sae_pkg::OP_AVG_TEMP;
                        end
                        default: begin
                            n_state = sae_pkg::ST_OUTPUT;
                        end
                    endcase
                end
            end
            sae_pkg::ST_UPDATE: begin
                n_state = sae_pkg::ST_DIV_START;
                n_op    = sae_pkg::OP_AVG_SUPPLY;
            end
            sae_pkg::ST_OUTPUT: begin
                if (i_sts.out_free) begin
                    n_state = sae_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sae_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load_in   = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.op        = r_op;
        o_cmd.update    = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            sae_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            sae_pkg::ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
            end
            sae_pkg::ST_DIV_WAIT: begin
                o_cmd.capture = i_sts.div_done;
            end
            sae_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            sae_pkg::ST_OUTPUT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire
